@@ sv/rqks_pkg.sv @@
// Shared types, codes and sizes of the ring queue with key search.
package rqks_pkg;

    // Ring geometry.
    localparam int DEPTH    = 8;
    localparam int ID_BYTES = 5;
    localparam int SLOT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Field widths of the beats.
    localparam int OP_W     = 3;
    localparam int TAG_W    = 40;
    localparam int DRINK_W  = 8;
    localparam int QUERY_W  = 3;
    localparam int STAT_W   = 2;
    localparam int FOUND_W  = 3;
    localparam int PLACE_W  = 4;
    localparam int ENTRY_W  = TAG_W + DRINK_W;

    // Bits of the identifier that take part in a find.
    localparam int ID_BITS  = (8 * ID_BYTES > TAG_W) ? TAG_W : 8 * ID_BYTES;

    // Width for place-in-line arithmetic: holds DEPTH, the query and the cap.
    localparam int POS_W    = (SLOT_W + 1 > PLACE_W) ? SLOT_W + 1 : PLACE_W;
    localparam int PLACE_MAX = 15;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
    localparam logic [OP_W-1:0] OP_POS    = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_F = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_R = 3'd5;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_REFUSE = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS   = 2'd2;

    typedef logic [SLOT_W-1:0] t_slot;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic step;
        logic peek_cap;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go_walk;
        logic go_peek;
        logic walk_end;
        logic out_busy;
    } t_stat;

    // Next slot around the ring.
    function automatic t_slot slot_next(input t_slot s);
        if (s == t_slot'(DEPTH - 1)) begin
            return '0;
        end
        return s + t_slot'(1);
    endfunction

endpackage

@@ sv/rqks_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rqks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rqks_ctrl.sv @@
// Sequencer of the ring queue: takes a beat, runs the operation, hands off the result.
module rqks_ctrl
    import rqks_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_PEEK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.go_walk) begin
                    n_state = S_CHECK;
                end else if (i_stat.go_peek) begin
                    n_state = S_PEEK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CHECK: begin
                // One ring entry is compared per cycle.
                o_cmd.step = 1'b1;
                if (i_stat.walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_PEEK: begin
                o_cmd.peek_cap = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                // Wait here while the previous result is still held.
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/rqks_dp.sv @@
// Datapath of the ring queue: pointers, entry store, search walk and result register.
module rqks_dp
    import rqks_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [TAG_W-1:0]   i_tag_id,
    input  logic [DRINK_W-1:0] i_drink_code,
    input  logic [QUERY_W-1:0] i_slot_query,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [STAT_W-1:0]  o_status,
    output logic [FOUND_W-1:0] o_slot_found,
    output logic [PLACE_W-1:0] o_line_place,
    output logic [TAG_W-1:0]   o_entry_tag,
    output logic [DRINK_W-1:0] o_entry_drink,
    output logic               o_ring_full,
    output logic               o_ring_empty
);

    // Latched input beat.
    logic [OP_W-1:0]    r_op;
    logic [TAG_W-1:0]   r_tag;
    logic [DRINK_W-1:0] r_drink;
    logic [QUERY_W-1:0] r_query;

    // Ring control state.
    t_slot r_head;
    t_slot r_tail;
    logic  r_empty;
    t_slot r_ptr;

    // Working result.
    logic [STAT_W-1:0]  r_status;
    logic [FOUND_W-1:0] r_found;
    logic [PLACE_W-1:0] r_place;
    logic [TAG_W-1:0]   r_etag;
    logic [DRINK_W-1:0] r_edrink;

    // Output register.
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_o_status;
    logic [FOUND_W-1:0] r_o_found;
    logic [PLACE_W-1:0] r_o_place;
    logic [TAG_W-1:0]   r_o_tag;
    logic [DRINK_W-1:0] r_o_drink;
    logic               r_o_full;
    logic               r_o_empty;

    t_slot              head_nx;
    t_slot              tail_nx;
    t_slot              ptr_nx;
    logic               ring_full;
    logic               push_ok;
    logic               tag_match;
    logic               at_tail;
    logic [ENTRY_W-1:0] rd_data;
    logic [TAG_W-1:0]   rd_tag;
    logic [DRINK_W-1:0] rd_drink;
    t_slot              wr_addr;
    t_slot              rd_addr;

    logic [POS_W-1:0]   q_ext;
    logic [POS_W-1:0]   h_ext;
    logic [POS_W-1:0]   t_ext;
    logic [POS_W-1:0]   q_dist;
    logic [POS_W-1:0]   span;
    logic [POS_W-1:0]   place_raw;
    logic               q_occupied;
    logic [PLACE_W-1:0] place_sat;

    assign head_nx   = slot_next(r_head);
    assign tail_nx   = slot_next(r_tail);
    assign ptr_nx    = slot_next(r_ptr);
    assign ring_full = !r_empty && (tail_nx == r_head);
    assign push_ok   = i_cmd.exec && (r_op == OP_PUSH) && !ring_full;

    // Entry store: an empty ring restarts at slot zero.
    assign wr_addr = r_empty ? '0 : tail_nx;
    assign rd_addr = i_cmd.step ? ptr_nx : ((r_op == OP_PEEK_R) ? r_tail : r_head);

    rqks_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (push_ok),
        .i_waddr (wr_addr),
        .i_wdata ({r_tag, r_drink}),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign rd_tag    = rd_data[ENTRY_W-1:DRINK_W];
    assign rd_drink  = rd_data[DRINK_W-1:0];
    assign tag_match = (rd_tag[ID_BITS-1:0] == r_tag[ID_BITS-1:0]);
    assign at_tail   = (r_ptr == r_tail);

    // Place in line of the queried slot, measured from the head.
    assign q_ext      = POS_W'(r_query);
    assign h_ext      = POS_W'(r_head);
    assign t_ext      = POS_W'(r_tail);
    assign q_dist     = (q_ext >= h_ext) ? (q_ext - h_ext) : (q_ext + POS_W'(DEPTH) - h_ext);
    assign span       = (t_ext >= h_ext) ? (t_ext - h_ext) : (t_ext + POS_W'(DEPTH) - h_ext);
    assign q_occupied = !r_empty && (q_ext < POS_W'(DEPTH)) && (q_dist <= span);
    assign place_raw  = q_dist + POS_W'(1);
    assign place_sat  = (place_raw > POS_W'(PLACE_MAX)) ? PLACE_W'(PLACE_MAX)
                                                        : place_raw[PLACE_W-1:0];

    // Status toward the controller.
    always_comb begin
        o_stat.go_walk  = (r_op == OP_FIND) && !r_empty;
        o_stat.go_peek  = ((r_op == OP_PEEK_F) || (r_op == OP_PEEK_R)) && !r_empty;
        o_stat.walk_end = tag_match || at_tail;
        o_stat.out_busy = r_out_valid && !i_ready;
    end

    // Ring pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.exec) begin
            if (push_ok) begin
                if (r_empty) begin
                    r_head  <= '0;
                    r_tail  <= '0;
                    r_empty <= 1'b0;
                end else begin
                    r_tail <= tail_nx;
                end
            end else if ((r_op == OP_POP) && !r_empty) begin
                if (r_head == r_tail) begin
                    r_empty <= 1'b1;
                end else begin
                    r_head <= head_nx;
                end
            end
        end
    end

    // Input latch, walk pointer and working result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= i_operation;
            r_tag   <= i_tag_id;
            r_drink <= i_drink_code;
            r_query <= i_slot_query;
        end
        if (i_cmd.exec) begin
            r_status <= ST_OK;
            r_found  <= '0;
            r_place  <= '0;
            r_etag   <= '0;
            r_edrink <= '0;
            r_ptr    <= r_head;
            unique case (r_op) inside
                OP_PUSH: begin
                    if (ring_full) begin
                        r_status <= ST_REFUSE;
                    end
                end
                OP_POP, OP_PEEK_F, OP_PEEK_R: begin
                    if (r_empty) begin
                        r_status <= ST_REFUSE;
                    end
                end
                OP_FIND: begin
                    r_status <= ST_MISS;
                end
                OP_POS: begin
                    if (q_occupied) begin
                        r_place <= place_sat;
                    end else begin
                        r_status <= ST_MISS;
                    end
                end
                default: begin
                end
            endcase
        end
        // Search walk: stop at the first match or at the tail.
        if (i_cmd.step) begin
            if (tag_match) begin
                r_status <= ST_OK;
                r_found  <= FOUND_W'(r_ptr);
            end else if (!at_tail) begin
                r_ptr <= ptr_nx;
            end
        end
        if (i_cmd.peek_cap) begin
            r_etag   <= rd_tag;
            r_edrink <= rd_drink;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload, with the ring flags as they stand after the operation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_place  <= r_place;
            r_o_tag    <= r_etag;
            r_o_drink  <= r_edrink;
            r_o_full   <= ring_full;
            r_o_empty  <= r_empty;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_o_status;
    assign o_slot_found  = r_o_found;
    assign o_line_place  = r_o_place;
    assign o_entry_tag   = r_o_tag;
    assign o_entry_drink = r_o_drink;
    assign o_ring_full   = r_o_full;
    assign o_ring_empty  = r_o_empty;

endmodule

@@ sv/ring_queue_with_key_search_top.sv @@
// Top level of the ring queue with key search.
//
// Input channel: i_valid / o_ready carry one operation beat (operation, tag_id,
// drink_code, slot_query). Output channel: o_valid / i_ready carry one result
// beat per operation (status, slot found, place in line, peeked entry, flags).
// The block takes one operation at a time. After the accepting edge, push, pop,
// position and the undefined codes run an execute step, then a done step whose
// load of the output register raises o_valid; a peek of a non-empty ring adds a
// capture step and a find on a non-empty ring adds walk steps over 1 to DEPTH
// entries from the head: the walk compares one stored entry per cycle through the
// single registered read port of the entry RAM.
// The next beat is taken in the cycle after the result moves into the output
// register, even while that result still waits for the receiver.
// When the receiver stalls, the result holds and a finished follow-up operation
// waits in its last step until the output register frees.
// Reset empties the ring (head and tail at slot zero) and drops any pending
// result; the entry RAM is not cleared, as only written slots are ever read.
module ring_queue_with_key_search_top
    import rqks_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [TAG_W-1:0]   i_tag_id,
    input  logic [DRINK_W-1:0] i_drink_code,
    input  logic [QUERY_W-1:0] i_slot_query,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [STAT_W-1:0]  o_status,
    output logic [FOUND_W-1:0] o_slot_found,
    output logic [PLACE_W-1:0] o_line_place,
    output logic [TAG_W-1:0]   o_entry_tag,
    output logic [DRINK_W-1:0] o_entry_drink,
    output logic               o_ring_full,
    output logic               o_ring_empty
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    rqks_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Datapath.
    rqks_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_tag_id      (i_tag_id),
        .i_drink_code  (i_drink_code),
        .i_slot_query  (i_slot_query),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot_found  (o_slot_found),
        .o_line_place  (o_line_place),
        .o_entry_tag   (o_entry_tag),
        .o_entry_drink (o_entry_drink),
        .o_ring_full   (o_ring_full),
        .o_ring_empty  (o_ring_empty)
    );

`ifndef NO_ASSERTIONS
    // A new beat is never taken in the cycle right after one was accepted.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while an operation is in progress");

    // A result cannot report a ring that is both full and empty.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_ring_full && o_ring_empty))
        else $error("result reports ring full and empty together");

    // A miss carries no slot and no place in line.
    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_MISS)) |-> ((o_slot_found == '0) && (o_line_place == '0)))
        else $error("not-found result carries data");

    // A refusal carries no peeked entry.
    a_refuse_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_REFUSE)) |-> ((o_entry_tag == '0) && (o_entry_drink == '0)))
        else $error("refused result carries entry data");
`endif

endmodule
